// File: sv/multichannel_mean_stddev_window_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef MULTICHANNEL_MEAN_STDDEV_WINDOW_UNIT_ASSERT_SVH
`define MULTICHANNEL_MEAN_STDDEV_WINDOW_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSW_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("msw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSW_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("msw assertion failed");

`endif

// File: sv/msw_pkg.sv
`timescale 1ns / 1ps
package msw_pkg;

  localparam int unsigned DEF_MAX_VOLTAGE_CHANNELS = 8;
  localparam int unsigned DEF_MAX_CURRENT_CHANNELS = 8;
  localparam int unsigned DEF_WINDOW_BITS          = 20;

  // Channel counts up to the sum of both class maxima (six bits wide, so at most 63).
  localparam int unsigned CH_CNT_W = 6;
  localparam int unsigned CFG_W    = 21;
  localparam int unsigned IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_VOLTAGE_CHANNELS = 3'd0;
  localparam logic [IDX_W-1:0] REG_CURRENT_CHANNELS = 3'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_FRAMES    = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOLTAGE_SCALE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CURRENT_SCALE    = 3'd4;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL_MEAN,
    BK_DIV_MEAN,
    BK_MUL_SQ,
    BK_MUL_NS,
    BK_MUL_X,
    BK_SQRT,
    BK_DIV_DEV,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic                valid;
    logic [CH_CNT_W-1:0] nv;
    logic [CH_CNT_W-1:0] total;
  } job_t;

  typedef struct packed {
    logic [2:0]  channel_index;
    logic        is_current;
    logic [31:0] mean_value;
    logic [30:0] deviation;
    logic        last;
  } result_t;

endpackage

// File: sv/msw_front.sv
`timescale 1ns / 1ps
module msw_front #(
  parameter int unsigned MAX_VOLTAGE_CHANNELS = msw_pkg::DEF_MAX_VOLTAGE_CHANNELS,
  parameter int unsigned MAX_CURRENT_CHANNELS = msw_pkg::DEF_MAX_CURRENT_CHANNELS,
  parameter int unsigned WINDOW_BITS          = msw_pkg::DEF_WINDOW_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  logic signed [15:0]                     sample,
  output logic                                   full,
  input  logic [3:0]                             nv_cfg,
  input  logic [3:0]                             nc_cfg,
  input  logic [msw_pkg::CFG_W-1:0]              win_cfg,
  output msw_pkg::job_t                          job,
  output logic [WINDOW_BITS:0]                   job_n,
  input  logic [$clog2(MAX_VOLTAGE_CHANNELS+MAX_CURRENT_CHANNELS)-1:0] rd_idx,
  output logic signed [WINDOW_BITS+16:0]         rd_sum,
  output logic [WINDOW_BITS+31:0]                rd_sq,
  input  logic                                   job_done
);

  localparam int unsigned NCH = MAX_VOLTAGE_CHANNELS + MAX_CURRENT_CHANNELS;
  localparam int unsigned PW  = $clog2(NCH);
  localparam int unsigned NW  = WINDOW_BITS + 1;
  localparam int unsigned SW  = WINDOW_BITS + 17;
  localparam int unsigned QW  = WINDOW_BITS + 32;
  localparam int unsigned CW  = (NW > msw_pkg::CFG_W) ? NW : msw_pkg::CFG_W;
  localparam int unsigned CHW = msw_pkg::CH_CNT_W;

  logic [PW-1:0]         pos;
  logic [NW-1:0]         cnt;
  logic signed [SW-1:0]  sum [NCH];
  logic [QW-1:0]         sq [NCH];
  logic signed [SW-1:0]  snap_sum [NCH];
  logic [QW-1:0]         snap_sq [NCH];
  logic signed [SW-1:0]  sum_next [NCH];
  logic [QW-1:0]         sq_next [NCH];

  logic [CHW-1:0]        nv;
  logic [CHW-1:0]        nc;
  logic [CHW-1:0]        total;
  logic [PW-1:0]         p;
  logic                  frame_end;
  logic [CW-1:0]         win_ext;
  logic [NW-1:0]         winc;
  logic [NW-1:0]         cnt_inc;
  logic                  win_end;
  logic                  accept;
  logic signed [SW-1:0]  s_ext;
  logic signed [31:0]    s_wide;
  logic [31:0]           s_sq;

  assign nv = ({2'b00, nv_cfg} > CHW'(MAX_VOLTAGE_CHANNELS)) ?
              CHW'(MAX_VOLTAGE_CHANNELS) : {2'b00, nv_cfg};
  assign nc = ({2'b00, nc_cfg} > CHW'(MAX_CURRENT_CHANNELS)) ?
              CHW'(MAX_CURRENT_CHANNELS) : {2'b00, nc_cfg};
  assign total = nv + nc;

  assign p         = (CHW'(pos) >= total) ? '0 : pos;
  assign frame_end = (CHW'(p) + CHW'(1)) == total;

  assign win_ext = CW'(win_cfg);
  always_comb begin
    if (win_ext == '0) begin
      winc = NW'(1);
    end else if (win_ext > (CW'(1) << WINDOW_BITS)) begin
      winc = NW'(1) << WINDOW_BITS;
    end else begin
      winc = NW'(win_ext);
    end
  end

  assign cnt_inc = cnt + NW'(1);
  assign win_end = frame_end && (cnt_inc >= winc);
  assign full    = job.valid && (total != '0) && win_end;
  assign accept  = push && !full;

  assign s_ext  = {{(SW-16){sample[15]}}, sample};
  assign s_wide = 32'(sample);
  assign s_sq   = s_wide * s_wide;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      if (PW'(i) == p) begin
        sum_next[i] = sum[i] + s_ext;
        sq_next[i]  = sq[i] + {{(QW-32){1'b0}}, s_sq};
      end else begin
        sum_next[i] = sum[i];
        sq_next[i]  = sq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      cnt       <= '0;
      job.valid <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        sum[i] <= '0;
        sq[i]  <= '0;
      end
    end else begin
      if (job_done) begin
        job.valid <= 1'b0;
      end
      if (accept && total != '0) begin
        if (win_end) begin
          for (int i = 0; i < NCH; i++) begin
            sum[i] <= '0;
            sq[i]  <= '0;
          end
          job.valid <= 1'b1;
          job.nv    <= nv;
          job.total <= total;
          job_n     <= cnt_inc;
          cnt       <= '0;
        end else begin
          for (int i = 0; i < NCH; i++) begin
            sum[i] <= sum_next[i];
            sq[i]  <= sq_next[i];
          end
          if (frame_end) begin
            cnt <= cnt_inc;
          end
        end
        pos <= frame_end ? '0 : p + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && total != '0 && win_end) begin
      for (int i = 0; i < NCH; i++) begin
        snap_sum[i] <= sum_next[i];
        snap_sq[i]  <= sq_next[i];
      end
    end
  end

  assign rd_sum = snap_sum[rd_idx];
  assign rd_sq  = snap_sq[rd_idx];

endmodule

// File: sv/msw_back.sv
`timescale 1ns / 1ps
module msw_back #(
  parameter int unsigned MAX_VOLTAGE_CHANNELS = msw_pkg::DEF_MAX_VOLTAGE_CHANNELS,
  parameter int unsigned MAX_CURRENT_CHANNELS = msw_pkg::DEF_MAX_CURRENT_CHANNELS,
  parameter int unsigned WINDOW_BITS          = msw_pkg::DEF_WINDOW_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  msw_pkg::job_t                          job,
  input  logic [WINDOW_BITS:0]                   job_n,
  output logic [$clog2(MAX_VOLTAGE_CHANNELS+MAX_CURRENT_CHANNELS)-1:0] rd_idx,
  input  logic signed [WINDOW_BITS+16:0]         rd_sum,
  input  logic [WINDOW_BITS+31:0]                rd_sq,
  output logic                                   job_done,
  input  logic [15:0]                            vscale,
  input  logic [15:0]                            cscale,
  output logic                                   oq_push,
  output msw_pkg::result_t                       res,
  input  logic                                   oq_full
);

  localparam int unsigned NCH  = MAX_VOLTAGE_CHANNELS + MAX_CURRENT_CHANNELS;
  localparam int unsigned PW   = $clog2(NCH);
  localparam int unsigned NW   = WINDOW_BITS + 1;
  localparam int unsigned SW   = WINDOW_BITS + 17;
  localparam int unsigned QW   = WINDOW_BITS + 32;
  localparam int unsigned AW   = 2 * SW + 32;
  localparam int unsigned BW   = (SW > 32) ? SW : 32;
  localparam int unsigned RW   = AW / 2;
  localparam int unsigned CNTW = $clog2(RW + 1);
  localparam int unsigned CHW  = msw_pkg::CH_CNT_W;

  msw_pkg::bk_state_t state, state_next;

  logic [PW-1:0]   k;
  logic            neg;
  logic [SW-1:0]   mag;
  logic [QW-1:0]   sqv;
  logic [31:0]     s2;
  logic [31:0]     mean;
  logic [30:0]     dev;
  logic [AW-1:0]   sq2;
  logic [AW-1:0]   ma;
  logic [BW-1:0]   mb;
  logic [AW-1:0]   macc;
  logic [AW-1:0]   sx;
  logic [RW+1:0]   srem;
  logic [RW-1:0]   sroot;
  logic [RW-1:0]   dq;
  logic [NW-1:0]   drem;
  logic [CNTW-1:0] cnt;

  logic            cur;
  logic            last_k;
  logic [15:0]     sc;
  logic [SW-1:0]   neg_sum;
  logic [SW-1:0]   mag_in;
  logic            mul_done;
  logic [RW+3:0]   rem2;
  logic [RW+3:0]   trial;
  logic            sge;
  logic [RW+3:0]   sdiff;
  logic [NW:0]     dr;
  logic            dge;
  logic [NW:0]     ddiff;
  logic [CHW-1:0]  idx;

  assign cur     = CHW'(k) >= job.nv;
  assign last_k  = (CHW'(k) + CHW'(1)) == job.total;
  assign sc      = cur ? cscale : vscale;
  assign neg_sum = -rd_sum;
  assign mag_in  = rd_sum[SW-1] ? neg_sum : rd_sum;
  assign rd_idx  = k;

  assign mul_done = (mb == '0);

  assign rem2  = {srem, sx[AW-1 -: 2]};
  assign trial = {2'b00, sroot, 2'b01};
  assign sge   = rem2 >= trial;
  assign sdiff = rem2 - trial;

  assign dr    = {drem, dq[RW-1]};
  assign dge   = dr >= {1'b0, job_n};
  assign ddiff = dr - {1'b0, job_n};

  assign idx                = cur ? CHW'(k) - job.nv : CHW'(k);
  assign res.channel_index  = idx[2:0];
  assign res.is_current     = cur;
  assign res.mean_value     = mean;
  assign res.deviation      = dev;
  assign res.last           = last_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msw_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    oq_push    = 1'b0;
    job_done   = 1'b0;
    unique case (state)
      msw_pkg::BK_IDLE: begin
        if (job.valid) state_next = msw_pkg::BK_LOAD;
      end
      msw_pkg::BK_LOAD: state_next = msw_pkg::BK_MUL_MEAN;
      msw_pkg::BK_MUL_MEAN: begin
        if (mul_done) state_next = msw_pkg::BK_DIV_MEAN;
      end
      msw_pkg::BK_DIV_MEAN: begin
        if (cnt == '0) state_next = msw_pkg::BK_MUL_SQ;
      end
      msw_pkg::BK_MUL_SQ: begin
        if (mul_done) state_next = msw_pkg::BK_MUL_NS;
      end
      msw_pkg::BK_MUL_NS: begin
        if (mul_done) state_next = msw_pkg::BK_MUL_X;
      end
      msw_pkg::BK_MUL_X: begin
        if (mul_done) state_next = msw_pkg::BK_SQRT;
      end
      msw_pkg::BK_SQRT: begin
        if (cnt == '0) state_next = msw_pkg::BK_DIV_DEV;
      end
      msw_pkg::BK_DIV_DEV: begin
        if (cnt == '0) state_next = msw_pkg::BK_EMIT;
      end
      msw_pkg::BK_EMIT: begin
        if (!oq_full) begin
          oq_push    = 1'b1;
          job_done   = last_k;
          state_next = last_k ? msw_pkg::BK_IDLE : msw_pkg::BK_LOAD;
        end
      end
      default: state_next = msw_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (state == msw_pkg::BK_IDLE) begin
      k <= '0;
    end else if (state == msw_pkg::BK_EMIT && !oq_full && !last_k) begin
      k <= k + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      msw_pkg::BK_LOAD: begin
        mag  <= mag_in;
        neg  <= rd_sum[SW-1];
        sqv  <= rd_sq;
        s2   <= sc * sc;
        ma   <= AW'(mag_in);
        mb   <= BW'(sc);
        macc <= '0;
      end
      msw_pkg::BK_MUL_MEAN, msw_pkg::BK_MUL_SQ, msw_pkg::BK_MUL_NS,
      msw_pkg::BK_MUL_X: begin
        if (!mul_done) begin
          if (mb[0]) macc <= macc + ma;
          ma <= ma << 1;
          mb <= mb >> 1;
        end else begin
          case (state)
            msw_pkg::BK_MUL_MEAN: begin
              dq   <= RW'(macc);
              drem <= '0;
              cnt  <= CNTW'(RW);
            end
            msw_pkg::BK_MUL_SQ: begin
              sq2  <= macc;
              ma   <= AW'(sqv);
              mb   <= BW'(job_n);
              macc <= '0;
            end
            msw_pkg::BK_MUL_NS: begin
              ma   <= (macc > sq2) ? macc - sq2 : '0;
              mb   <= BW'(s2);
              macc <= '0;
            end
            default: begin
              sx    <= macc;
              srem  <= '0;
              sroot <= '0;
              cnt   <= CNTW'(RW);
            end
          endcase
        end
      end
      msw_pkg::BK_DIV_MEAN, msw_pkg::BK_DIV_DEV: begin
        if (cnt != '0) begin
          drem <= dge ? ddiff[NW-1:0] : dr[NW-1:0];
          dq   <= {dq[RW-2:0], dge};
          cnt  <= cnt - CNTW'(1);
        end else if (state == msw_pkg::BK_DIV_MEAN) begin
          mean <= neg ? -dq[31:0] : dq[31:0];
          ma   <= AW'(mag);
          mb   <= BW'(mag);
          macc <= '0;
        end else begin
          dev <= dq[30:0];
        end
      end
      msw_pkg::BK_SQRT: begin
        if (cnt != '0) begin
          srem  <= sge ? sdiff[RW+1:0] : rem2[RW+1:0];
          sroot <= {sroot[RW-2:0], sge};
          sx    <= sx << 2;
          cnt   <= cnt - CNTW'(1);
        end else begin
          dq   <= sroot;
          drem <= '0;
          cnt  <= CNTW'(RW);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/msw_outq.sv
`timescale 1ns / 1ps
module msw_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  msw_pkg::result_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output msw_pkg::result_t rd_data,
  output logic             empty
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  msw_pkg::result_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == (AW+1)'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= rd_ptr + AW'(1);
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

// File: sv/multichannel_mean_stddev_window_unit.sv
`timescale 1ns / 1ps
// Windowed mean and standard deviation over interleaved converter samples.
// Input channel: push a signed sample while full is low; one sample is
// taken per cycle unless full is high, voltage channels first, then
// current channels, frame after frame. Sum and sum of squares are
// accumulated in registers. When a frame completes the window, the sums
// are copied to a snapshot and cleared, and a back end works through the
// channels one at a time: a shift-add multiplier, a restoring divider and
// a two-bits-per-step square root give each result.
// full rises only when a window ends while the previous snapshot is still
// being worked on. Result channel: the oldest result waits on the output
// ports while empty is low and is removed by pop; a four-entry queue holds
// results, and when the receiver stalls the back end waits at its output.
// Reset clears the sums, the frame count and the output queue, and loads
// the default configuration. The user writes the configuration through
// cfg_write, cfg_index and cfg_data only while idle; the block does not enforce it.
module multichannel_mean_stddev_window_unit #(
  parameter int unsigned MAX_VOLTAGE_CHANNELS = msw_pkg::DEF_MAX_VOLTAGE_CHANNELS,
  parameter int unsigned MAX_CURRENT_CHANNELS = msw_pkg::DEF_MAX_CURRENT_CHANNELS,
  parameter int unsigned WINDOW_BITS          = msw_pkg::DEF_WINDOW_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [15:0]          sample,
  output logic                        empty,
  input  logic                        pop,
  output logic [2:0]                  channel_index,
  output logic                        is_current,
  output logic signed [31:0]          mean_value,
  output logic [30:0]                 deviation,
  output logic                        last,
  input  logic                        cfg_write,
  input  logic [msw_pkg::IDX_W-1:0]   cfg_index,
  input  logic [msw_pkg::CFG_W-1:0]   cfg_data
);

  localparam int unsigned NCH = MAX_VOLTAGE_CHANNELS + MAX_CURRENT_CHANNELS;
  localparam int unsigned PW  = $clog2(NCH);

  logic [3:0]                  voltage_channels;
  logic [3:0]                  current_channels;
  logic [msw_pkg::CFG_W-1:0]   window_frames;
  logic [15:0]                 voltage_scale;
  logic [15:0]                 current_scale;

  msw_pkg::job_t               job;
  logic [WINDOW_BITS:0]        job_n;
  logic [PW-1:0]               rd_idx;
  logic signed [WINDOW_BITS+16:0] rd_sum;
  logic [WINDOW_BITS+31:0]     rd_sq;
  logic                        job_done;
  logic                        oq_push;
  logic                        oq_full;
  msw_pkg::result_t            res;
  msw_pkg::result_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_channels <= 4'd1;
      current_channels <= 4'd1;
      window_frames    <= msw_pkg::CFG_W'(1000);
      voltage_scale    <= 16'd256;
      current_scale    <= 16'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        msw_pkg::REG_VOLTAGE_CHANNELS: voltage_channels <= cfg_data[3:0];
        msw_pkg::REG_CURRENT_CHANNELS: current_channels <= cfg_data[3:0];
        msw_pkg::REG_WINDOW_FRAMES:    window_frames    <= cfg_data;
        msw_pkg::REG_VOLTAGE_SCALE:    voltage_scale    <= cfg_data[15:0];
        msw_pkg::REG_CURRENT_SCALE:    current_scale    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  msw_front #(
    .MAX_VOLTAGE_CHANNELS(MAX_VOLTAGE_CHANNELS),
    .MAX_CURRENT_CHANNELS(MAX_CURRENT_CHANNELS),
    .WINDOW_BITS(WINDOW_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .sample(sample),
    .full(full),
    .nv_cfg(voltage_channels),
    .nc_cfg(current_channels),
    .win_cfg(window_frames),
    .job(job),
    .job_n(job_n),
    .rd_idx(rd_idx),
    .rd_sum(rd_sum),
    .rd_sq(rd_sq),
    .job_done(job_done)
  );

  msw_back #(
    .MAX_VOLTAGE_CHANNELS(MAX_VOLTAGE_CHANNELS),
    .MAX_CURRENT_CHANNELS(MAX_CURRENT_CHANNELS),
    .WINDOW_BITS(WINDOW_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job(job),
    .job_n(job_n),
    .rd_idx(rd_idx),
    .rd_sum(rd_sum),
    .rd_sq(rd_sq),
    .job_done(job_done),
    .vscale(voltage_scale),
    .cscale(current_scale),
    .oq_push(oq_push),
    .res(res),
    .oq_full(oq_full)
  );

  msw_outq u_outq (
    .clk(clk),
    .rst(rst),
    .wr_en(oq_push),
    .wr_data(res),
    .full(oq_full),
    .rd_en(pop),
    .rd_data(head),
    .empty(empty)
  );

  assign channel_index = head.channel_index;
  assign is_current    = head.is_current;
  assign mean_value    = head.mean_value;
  assign deviation     = head.deviation;
  assign last          = head.last;

endmodule

// File: sv/msw_checker.sv
`timescale 1ns / 1ps
`include "multichannel_mean_stddev_window_unit_assert.svh"
module msw_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic        cfg_write,
  input logic [2:0]  channel_index,
  input logic        is_current,
  input logic [31:0] mean_value,
  input logic [30:0] deviation,
  input logic        last
);

  logic [67:0] head_bits;

  assign head_bits = {channel_index, is_current, mean_value, deviation, last};

  // Reset leaves no result waiting and the input open.
  `MSW_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, empty && !full)

  // Without a transfer or a register write, the input cannot become blocked.
  `MSW_ASSERT_NEXT(a_full_no_rise, clk, rst, !full && !push && !cfg_write, !full)

  // A waiting result that is not taken stays unchanged.
  `MSW_ASSERT_NEXT(a_result_held, clk, rst, !empty && !pop, !empty && $stable(head_bits))

endmodule

bind multichannel_mean_stddev_window_unit msw_checker u_msw_checker (.*);
